// ===== rtl/sps_pkg.sv =====
package sps_pkg;

    localparam int GOLOMB_MAX_ZEROS_DEF = 31;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [5:0] {
        S_HDR, S_PROF, S_CONS, S_LEVEL, S_SPSID, S_CHROMA, S_RESID, S_DEPTHL,
        S_DEPTHC, S_BYPASS, S_SCLPRES, S_SCLFLAGS, S_FRAMENUM, S_POCTYPE,
        S_POCLSB, S_DELTAZERO, S_NONREF, S_TOPBOT, S_NCYCLE, S_CYCOFF, S_NUMREF,
        S_GAPS, S_WIDTH, S_HEIGHT, S_FRAMEMBS, S_MBAFF, S_DIRECT, S_CROPFLAG,
        S_CROP, S_VUIFLAG, S_ARFLAG, S_ARIDC, S_SAR, S_OVFLAG, S_OVAPP, S_VSFLAG,
        S_VSINFO, S_COLOUR, S_CHLOCFLAG, S_CHLOC, S_TIMFLAG, S_NUIT, S_TSCALE,
        S_FIXED, S_DONE
    } step_t;

    typedef enum logic [1:0] {
        B_IDLE, B_BITS, B_DIV, B_OUT
    } back_state_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_NOT_SPS   = 3'd2,
        ST_TRUNC     = 3'd3,
        ST_MALFORMED = 3'd4
    } status_t;

    localparam logic [7:0] EPB_BYTE   = 8'h03;
    localparam logic [4:0] NAL_SPS    = 5'd7;
    localparam logic [7:0] AR_EXT_SAR = 8'd255;

    // queued work item from the front end
    typedef struct packed {
        logic [7:0] bits;
        logic       feed;
        logic       last;
        logic       short_unit;
    } work_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [16:0] width_px;
        logic [16:0] height_px;
        logic [31:0] frame_rate;
        logic        rate_present;
    } result_t;

    // fixed field length; 0 marks an exp-Golomb code
    function automatic logic [5:0] step_len(input step_t s);
        unique case (s)
            S_HDR, S_PROF, S_CONS, S_LEVEL, S_SCLFLAGS, S_ARIDC: step_len = 6'd8;
            S_RESID, S_BYPASS, S_SCLPRES, S_DELTAZERO, S_GAPS, S_FRAMEMBS,
            S_MBAFF, S_DIRECT, S_CROPFLAG, S_VUIFLAG, S_ARFLAG, S_OVFLAG,
            S_OVAPP, S_VSFLAG, S_CHLOCFLAG, S_TIMFLAG, S_FIXED: step_len = 6'd1;
            S_SAR, S_NUIT, S_TSCALE: step_len = 6'd32;
            S_VSINFO: step_len = 6'd5;
            S_COLOUR: step_len = 6'd24;
            default: step_len = 6'd0;
        endcase
    endfunction

    function automatic logic [16:0] size_px(input logic [31:0] v);
        logic [32:0] p;
        p = {1'b0, v} + 33'd1;
        size_px = (p > 33'd4096) ? 17'd65536 : {p[12:0], 4'b0000};
    endfunction

endpackage

// ===== rtl/sps_stream_if.sv =====
interface sps_stream_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/h264_sps_header_parser.sv =====
// Channel   Dir  Payload                                            Handshake
// in_ch     in   data_byte[7:0], last_byte                          valid/ready
// out_ch    out  status, width_px, height_px, frame_rate, rate_present  valid/ready
//
// Each kept byte is loaded into the bit-serial syntax walker, which then walks
// its eight bits; the last byte also goes through the 32-step divider and the
// result stage. A two-entry queue separates byte intake from the walker.
// rst_n clears all control state asynchronously; the walker returns to the
// header step after every emitted result. A stalled output holds its result
// while the front keeps filling the queue.
module h264_sps_header_parser
    import sps_pkg::*;
#(
    parameter int GOLOMB_MAX_ZEROS = GOLOMB_MAX_ZEROS_DEF
)
(
    input logic clk,
    input logic rst_n,
    sps_stream_if.sink   in_ch,
    sps_stream_if.source out_ch
);
    logic    q_valid, q_ready;
    work_t   q_item;
    result_t res;

    sps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .data_byte (in_ch.payload[7:0]),
        .last_byte (in_ch.payload[8]),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item)
    );

    sps_back #(
        .GOLOMB_MAX_ZEROS (GOLOMB_MAX_ZEROS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (res)
    );

    assign out_ch.payload = res;
endmodule

// ===== rtl/sps_front.sv =====
module sps_front
    import sps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        q_valid,
    input  logic        q_ready,
    output work_t       q_item
);
    localparam int QAW = $clog2(QUEUE_DEPTH);

    logic [1:0] zero_run_reg, zero_run_next;
    logic [2:0] byte_count_reg, byte_count_next;
    work_t      q_mem [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   fill_reg;
    logic       push, pop, drop;
    logic [2:0] cnt_inc;
    work_t      w_item;

    assign in_ready = (fill_reg != QUEUE_DEPTH[QAW:0]);
    assign push     = in_valid && in_ready;
    assign q_valid  = (fill_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_item   = q_mem[rd_ptr_reg];

    // classify the byte: drop emulation prevention, track unit length
    always_comb
    begin
        drop    = (zero_run_reg == 2'd2) && (data_byte == EPB_BYTE);
        cnt_inc = (byte_count_reg < 3'd6) ? byte_count_reg + 3'd1 : byte_count_reg;
        if (drop)
        begin
            zero_run_next = 2'd0;
        end
        else if (data_byte == 8'd0)
        begin
            zero_run_next = (zero_run_reg < 2'd2) ? zero_run_reg + 2'd1 : 2'd2;
        end
        else
        begin
            zero_run_next = 2'd0;
        end
        byte_count_next = cnt_inc;
        if (last_byte)
        begin
            zero_run_next   = 2'd0;
            byte_count_next = 3'd0;
        end
        w_item.bits       = data_byte;
        w_item.feed       = !drop;
        w_item.last       = last_byte;
        w_item.short_unit = (cnt_inc < 3'd6);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg   <= '0;
            byte_count_reg <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fill_reg       <= '0;
        end
        else
        begin
            if (push)
            begin
                zero_run_reg   <= zero_run_next;
                byte_count_reg <= byte_count_next;
                wr_ptr_reg     <= (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_reg + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end

    // hold queued items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= w_item;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= QUEUE_DEPTH[QAW:0])
        else $error("queue overfilled");
    assert property (@(posedge clk) disable iff (!rst_n)
        push && last_byte |=> byte_count_reg == 3'd0 && zero_run_reg == 2'd0)
        else $error("unit counters not cleared");
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> !pop)
        else $error("pop from empty queue");
endmodule

// ===== rtl/sps_divider.sv =====
module sps_divider
    import sps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);
    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] trial;

    assign busy     = (cnt_reg != 6'd0);
    assign quotient = q_reg;

    // one restoring step a cycle
    always_comb
    begin
        trial  = {r_reg, q_reg[31]} - {1'b0, d_reg};
        q_next = {q_reg[30:0], !trial[32]};
        r_next = trial[32] ? {r_reg[30:0], q_reg[31]} : trial[31:0];
        cnt_next = cnt_reg - 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= 6'd32;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end
endmodule

// ===== rtl/sps_back.sv =====
module sps_back
    import sps_pkg::*;
#(
    parameter int GOLOMB_MAX_ZEROS = GOLOMB_MAX_ZEROS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    output logic    q_ready,
    input  work_t   q_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);
    back_state_t state_reg, state_next;
    step_t       step_reg;
    logic [7:0]  sh_reg;
    logic [2:0]  bit_reg;
    logic        last_reg, short_reg, fixed_flag_reg;
    logic [5:0]  gz_reg;
    logic [31:0] gv_reg;
    logic [5:0]  left_reg;
    logic [7:0]  prof_reg;
    logic [31:0] loop_reg;
    logic [16:0] w_reg, h_reg;
    logic [31:0] tick_reg, scale_reg;
    logic        timing_reg;
    logic [2:0]  err_reg;
    logic        res_valid_reg;
    result_t     res_reg;

    logic        b, is_fixed, fin;
    logic [31:0] fin_v, gv_sh;
    step_t       nx;
    logic        div_start, div_busy;
    logic [31:0] div_q;
    logic        active;
    logic [2:0]  st;

    sps_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scale_reg),
        .divisor  (tick_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign q_ready   = (state_reg == B_IDLE);
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
                if (q_valid)
                begin
                    state_next = q_item.feed ? B_BITS
                               : (q_item.last ? B_DIV : B_IDLE);
                end
            B_BITS:
                if (bit_reg == 3'd7)
                begin
                    state_next = last_reg ? B_DIV : B_IDLE;
                end
            B_DIV:
                if (!div_busy)
                begin
                    state_next = B_OUT;
                end
            B_OUT:
                if (!res_valid_reg || out_ready)
                begin
                    state_next = B_IDLE;
                end
            default: state_next = B_IDLE;
        endcase
    end

    // syntax walker bit decode
    always_comb
    begin
        b        = sh_reg[7];
        active   = (state_reg == B_BITS) && (err_reg == 3'd0) && (step_reg != S_DONE);
        is_fixed = (step_len(step_reg) != 6'd0);
        gv_sh    = {gv_reg[30:0], b};
        fin      = 1'b0;
        fin_v    = gv_sh;
        if (is_fixed)
        begin
            fin = (left_reg == 6'd1);
        end
        else if (left_reg == 6'd0)
        begin
            fin   = b && (gz_reg == 6'd0);
            fin_v = '0;
        end
        else
        begin
            fin   = (left_reg == 6'd1);
            fin_v = ((32'd1 << gz_reg) - 32'd1) + gv_sh;
        end
        nx = step_t'(step_reg + 6'd1);
        unique case (step_reg)
            S_SPSID: nx = (prof_reg == 8'd100 || prof_reg == 8'd110 ||
                           prof_reg == 8'd122 || prof_reg == 8'd144) ? S_CHROMA : S_FRAMENUM;
            S_CHROMA: nx = (fin_v == 32'd3) ? S_RESID : S_DEPTHL;
            S_SCLPRES: nx = (fin_v != 0) ? S_SCLFLAGS : S_FRAMENUM;
            S_POCTYPE: nx = (fin_v == 0) ? S_POCLSB : ((fin_v == 1) ? S_DELTAZERO : S_NUMREF);
            S_POCLSB: nx = S_NUMREF;
            S_NCYCLE: nx = (fin_v != 0) ? S_CYCOFF : S_NUMREF;
            S_CYCOFF: nx = (loop_reg != 32'd1) ? S_CYCOFF : S_NUMREF;
            S_FRAMEMBS: nx = (fin_v != 0) ? S_DIRECT : S_MBAFF;
            S_CROPFLAG: nx = (fin_v != 0) ? S_CROP : S_VUIFLAG;
            S_CROP: nx = (loop_reg != 32'd1) ? S_CROP : S_VUIFLAG;
            S_VUIFLAG: nx = (fin_v != 0) ? S_ARFLAG : S_DONE;
            S_ARFLAG: nx = (fin_v != 0) ? S_ARIDC : S_OVFLAG;
            S_ARIDC: nx = (fin_v == {24'd0, AR_EXT_SAR}) ? S_SAR : S_OVFLAG;
            S_OVFLAG: nx = (fin_v != 0) ? S_OVAPP : S_VSFLAG;
            S_VSFLAG: nx = (fin_v != 0) ? S_VSINFO : S_CHLOCFLAG;
            S_VSINFO: nx = fin_v[0] ? S_COLOUR : S_CHLOCFLAG;
            S_CHLOCFLAG: nx = (fin_v != 0) ? S_CHLOC : S_TIMFLAG;
            S_CHLOC: nx = (loop_reg != 32'd1) ? S_CHLOC : S_TIMFLAG;
            S_TIMFLAG: nx = (fin_v != 0) ? S_NUIT : S_DONE;
            S_FIXED: nx = S_DONE;
            default: nx = step_t'(step_reg + 6'd1);
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        div_start = (state_reg == B_IDLE) && q_valid && !q_item.feed && q_item.last
                 || (state_reg == B_BITS) && (bit_reg == 3'd7) && last_reg;
        if (short_reg)
        begin
            st = ST_SHORT;
        end
        else if (err_reg != 3'd0)
        begin
            st = err_reg;
        end
        else if (step_reg != S_DONE)
        begin
            st = ST_TRUNC;
        end
        else
        begin
            st = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            res_valid_reg <= 1'b0;
            step_reg      <= S_HDR;
            gz_reg <= '0; gv_reg <= '0; left_reg <= 6'd8;
            prof_reg <= '0; loop_reg <= '0; w_reg <= '0; h_reg <= '0;
            tick_reg <= '0; scale_reg <= '0; timing_reg <= 1'b0; err_reg <= '0;
            fixed_flag_reg <= 1'b0; bit_reg <= '0; last_reg <= 1'b0; short_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // raise the result on emit, drop it once taken
            if (state_reg == B_OUT && state_next == B_IDLE)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            // take a byte from the queue
            if (state_reg == B_IDLE && q_valid)
            begin
                bit_reg   <= '0;
                last_reg  <= q_item.last;
                short_reg <= q_item.short_unit;
            end
            if (state_reg == B_BITS)
            begin
                bit_reg <= bit_reg + 3'd1;
            end
            // advance the walker by one bit
            if (active)
            begin
                if (fin)
                begin
                    if (step_reg == S_HDR && fin_v[4:0] != NAL_SPS)
                    begin
                        err_reg <= ST_NOT_SPS;
                    end
                    else
                    begin
                        step_reg <= nx;
                        gz_reg   <= '0;
                        gv_reg   <= '0;
                        left_reg <= (nx == S_DONE) ? 6'd0 : step_len(nx);
                        unique case (step_reg)
                            S_PROF: prof_reg <= fin_v[7:0];
                            S_NCYCLE: loop_reg <= fin_v;
                            S_CYCOFF, S_CROP, S_CHLOC: loop_reg <= loop_reg - 32'd1;
                            S_CROPFLAG: loop_reg <= 32'd4;
                            S_CHLOCFLAG: loop_reg <= 32'd2;
                            S_WIDTH: w_reg <= size_px(fin_v);
                            S_HEIGHT: h_reg <= size_px(fin_v);
                            S_TIMFLAG: timing_reg <= fin_v[0];
                            S_NUIT: tick_reg <= fin_v;
                            S_TSCALE: scale_reg <= fin_v;
                            S_FIXED: fixed_flag_reg <= fin_v[0];
                            default: ;
                        endcase
                    end
                end
                else if (is_fixed || left_reg != 6'd0)
                begin
                    gv_reg   <= gv_sh;
                    left_reg <= left_reg - 6'd1;
                end
                else if (!b)
                begin
                    gz_reg <= gz_reg + 6'd1;
                    if (gz_reg + 6'd1 > 6'(GOLOMB_MAX_ZEROS))
                    begin
                        err_reg <= ST_MALFORMED;
                    end
                end
                else
                begin
                    left_reg <= gz_reg;
                    gv_reg   <= '0;
                end
            end
            // emit the result and return to the header step
            if (state_reg == B_OUT && state_next == B_IDLE)
            begin
                step_reg <= S_HDR;
                gz_reg <= '0; gv_reg <= '0; left_reg <= 6'd8;
                prof_reg <= '0; loop_reg <= '0; w_reg <= '0; h_reg <= '0;
                tick_reg <= '0; scale_reg <= '0; timing_reg <= 1'b0; err_reg <= '0;
                fixed_flag_reg <= 1'b0;
            end
        end
    end

    // shift byte bits and latch the result
    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && q_valid)
        begin
            sh_reg <= q_item.bits;
        end
        else if (state_reg == B_BITS)
        begin
            sh_reg <= {sh_reg[6:0], 1'b0};
        end
        if (state_reg == B_OUT && state_next == B_IDLE)
        begin
            res_reg.status <= st;
            if (st == ST_OK)
            begin
                res_reg.width_px     <= w_reg;
                res_reg.height_px    <= h_reg;
                res_reg.rate_present <= timing_reg && step_reg == S_DONE && tick_reg != 0;
                res_reg.frame_rate   <= (timing_reg && tick_reg != 0)
                                       ? (fixed_flag_reg ? {1'b0, div_q[31:1]} : div_q)
                                       : 32'd0;
            end
            else
            begin
                res_reg.width_px     <= '0;
                res_reg.height_px    <= '0;
                res_reg.rate_present <= 1'b0;
                res_reg.frame_rate   <= '0;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_DIV |-> !q_ready)
        else $error("accepted byte during division");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.rate_present == 1'b0)
        else $error("rate flagged on error");
endmodule

// ===== bench/tb_h264_sps_header_parser.sv =====
`timescale 1ns / 100ps

module tb_h264_sps_header_parser;
    import sps_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BYTES   = 650;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 80;

    logic clk;
    logic rst_n;

    sps_stream_if #(.W(9)) in_if ();
    sps_stream_if #(.W($bits(result_t))) out_if ();

    h264_sps_header_parser u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if.sink),
        .out_ch (out_if.source)
    );

    // directed stimulus row; typed rows carry a hand-written expectation
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       typed;
        result_t    want;
    } vec_row_t;

    localparam result_t R_SHORT = '{status: ST_SHORT, default: '0};
    localparam result_t R_NOSPS = '{status: ST_NOT_SPS, default: '0};
    localparam result_t R_BADC  = '{status: ST_MALFORMED, default: '0};
    localparam result_t R_MIN   = '{status: ST_OK, width_px: 17'd16, height_px: 17'd16,
                                    default: '0};

    vec_row_t dir_rows[] = '{
        // one-byte unit
        '{8'h67, 1'b1, 1'b1, R_SHORT},
        // five bytes, still too short
        '{8'h67, 1'b0, 1'b0, '0}, '{8'h42, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h1e, 1'b0, 1'b0, '0}, '{8'h80, 1'b1, 1'b1, R_SHORT},
        // wrong NAL type
        '{8'h68, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b1, 1'b1, R_NOSPS},
        // 32-zero Golomb prefix
        '{8'h67, 1'b0, 1'b0, '0}, '{8'h42, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h1e, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b1, 1'b1, R_BADC},
        // smallest complete SPS, no VUI
        '{8'h67, 1'b0, 1'b0, '0}, '{8'h42, 1'b0, 1'b0, '0}, '{8'hc0, 1'b0, 1'b0, '0},
        '{8'h1e, 1'b0, 1'b0, '0}, '{8'hff, 1'b0, 1'b0, '0}, '{8'h80, 1'b1, 1'b1, R_MIN}
    };

    result_t sps_expect_q[$];
    int      err_count;
    int      idle_pct;
    bit      hold_req;
    int      quiet_cycles = 0;

    // predictor state
    logic [1:0]  p_zrun;
    logic [2:0]  p_bcnt;
    step_t       p_step;
    logic [5:0]  p_gzeros;
    logic [31:0] p_gval;
    logic [5:0]  p_left;
    logic [7:0]  p_prof;
    logic [31:0] p_loop;
    logic [16:0] p_wid, p_hgt;
    logic [31:0] p_tick, p_scale, p_rate;
    logic        p_timing;
    logic [2:0]  p_err;

    function automatic logic [5:0] field_len(step_t s);
        case (s)
            S_HDR, S_PROF, S_CONS, S_LEVEL, S_SCLFLAGS, S_ARIDC: return 6'd8;
            S_RESID, S_BYPASS, S_SCLPRES, S_DELTAZERO, S_GAPS, S_FRAMEMBS, S_MBAFF,
            S_DIRECT, S_CROPFLAG, S_VUIFLAG, S_ARFLAG, S_OVFLAG, S_OVAPP, S_VSFLAG,
            S_CHLOCFLAG, S_TIMFLAG, S_FIXED: return 6'd1;
            S_SAR, S_NUIT, S_TSCALE: return 6'd32;
            S_VSINFO: return 6'd5;
            S_COLOUR: return 6'd24;
            default: return 6'd0;
        endcase
    endfunction

    function automatic logic [16:0] mb_pixels(logic [31:0] v);
        longint unsigned p;
        p = (longint'(v) + 1) * 16;
        return (p > 65536) ? 17'd65536 : 17'(p);
    endfunction

    task automatic goto_step(step_t s);
        p_step   = s;
        p_gzeros = '0;
        p_gval   = '0;
        p_left   = (s == S_DONE) ? 6'd0 : field_len(s);
    endtask

    task automatic clear_walker();
        p_zrun = '0; p_bcnt = '0; p_prof = '0; p_loop = '0;
        p_wid = '0; p_hgt = '0; p_tick = '0; p_scale = '0; p_rate = '0;
        p_timing = 1'b0; p_err = '0;
        goto_step(S_HDR);
    endtask

    // close one syntax element and pick the next step
    task automatic close_field(logic [31:0] v);
        step_t nx;
        nx = step_t'(p_step + 1);
        case (p_step)
            S_HDR:
                if (v[4:0] != NAL_SPS) begin
                    p_err = ST_NOT_SPS;
                    return;
                end
            S_PROF: p_prof = v[7:0];
            S_SPSID: nx = (p_prof inside {8'd100, 8'd110, 8'd122, 8'd144}) ?
                          S_CHROMA : S_FRAMENUM;
            S_CHROMA: nx = (v == 3) ? S_RESID : S_DEPTHL;
            S_SCLPRES: nx = (v != 0) ? S_SCLFLAGS : S_FRAMENUM;
            S_POCTYPE: nx = (v == 0) ? S_POCLSB : ((v == 1) ? S_DELTAZERO : S_NUMREF);
            S_POCLSB: nx = S_NUMREF;
            S_NCYCLE:
            begin
                p_loop = v;
                nx = (v != 0) ? S_CYCOFF : S_NUMREF;
            end
            S_CYCOFF:
            begin
                p_loop = p_loop - 32'd1;
                nx = (p_loop != 0) ? S_CYCOFF : S_NUMREF;
            end
            S_WIDTH: p_wid = mb_pixels(v);
            S_HEIGHT: p_hgt = mb_pixels(v);
            S_FRAMEMBS: nx = (v != 0) ? S_DIRECT : S_MBAFF;
            S_CROPFLAG:
            begin
                p_loop = 32'd4;
                nx = (v != 0) ? S_CROP : S_VUIFLAG;
            end
            S_CROP:
            begin
                p_loop = p_loop - 32'd1;
                nx = (p_loop != 0) ? S_CROP : S_VUIFLAG;
            end
            S_VUIFLAG: nx = (v != 0) ? S_ARFLAG : S_DONE;
            S_ARFLAG: nx = (v != 0) ? S_ARIDC : S_OVFLAG;
            S_ARIDC: nx = (v == AR_EXT_SAR) ? S_SAR : S_OVFLAG;
            S_OVFLAG: nx = (v != 0) ? S_OVAPP : S_VSFLAG;
            S_VSFLAG: nx = (v != 0) ? S_VSINFO : S_CHLOCFLAG;
            S_VSINFO: nx = v[0] ? S_COLOUR : S_CHLOCFLAG;
            S_CHLOCFLAG:
            begin
                p_loop = 32'd2;
                nx = (v != 0) ? S_CHLOC : S_TIMFLAG;
            end
            S_CHLOC:
            begin
                p_loop = p_loop - 32'd1;
                nx = (p_loop != 0) ? S_CHLOC : S_TIMFLAG;
            end
            S_TIMFLAG:
            begin
                p_timing = v[0];
                nx = (v != 0) ? S_NUIT : S_DONE;
            end
            S_NUIT: p_tick = v;
            S_TSCALE: p_scale = v;
            S_FIXED:
            begin
                if (p_tick != 0)
                begin
                    p_rate = p_scale / p_tick;
                    if (v != 0)
                        p_rate = p_rate >> 1;
                end
                else
                    p_rate = '0;
                nx = S_DONE;
            end
            default: ;
        endcase
        goto_step(nx);
    endtask

    task automatic walk_bit(logic b);
        longint unsigned g;
        if (p_err != 0 || p_step == S_DONE)
            return;
        if (field_len(p_step) != 0)
        begin
            p_gval = {p_gval[30:0], b};
            p_left = p_left - 6'd1;
            if (p_left == 0)
                close_field(p_gval);
        end
        else if (p_left == 0)
        begin
            if (!b)
            begin
                p_gzeros = p_gzeros + 6'd1;
                if (p_gzeros > GOLOMB_MAX_ZEROS_DEF)
                    p_err = ST_MALFORMED;
            end
            else if (p_gzeros == 0)
                close_field('0);
            else
            begin
                p_left = p_gzeros;
                p_gval = '0;
            end
        end
        else
        begin
            p_gval = {p_gval[30:0], b};
            p_left = p_left - 6'd1;
            if (p_left == 0)
            begin
                g = ((64'd1 << p_gzeros) - 1) + p_gval;
                close_field(g[31:0]);
            end
        end
    endtask

    // advance the predictor by one accepted byte; queue a result on the last one
    task automatic predict_byte(logic [7:0] data, logic last, logic typed, result_t want);
        result_t r;
        if (p_bcnt < 6)
            p_bcnt = p_bcnt + 3'd1;
        if (p_zrun >= 2 && data == EPB_BYTE)
            p_zrun = '0;
        else
        begin
            p_zrun = (data == 0) ? ((p_zrun < 2) ? p_zrun + 2'd1 : 2'd2) : 2'd0;
            for (int i = 7; i >= 0; i--)
                walk_bit(data[i]);
        end
        if (!last)
            return;
        r = '0;
        if (p_bcnt < 6)
            r.status = ST_SHORT;
        else if (p_err != 0)
            r.status = p_err;
        else if (p_step != S_DONE)
            r.status = ST_TRUNC;
        else
        begin
            r.status       = ST_OK;
            r.width_px     = p_wid;
            r.height_px    = p_hgt;
            r.rate_present = p_timing && (p_tick != 0);
            r.frame_rate   = r.rate_present ? p_rate : '0;
        end
        sps_expect_q.push_back(typed ? want : r);
        clear_walker();
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: check accepted transactions, drive ready
    initial
    begin : result_side
        result_t got, want;
        int      hold_left;
        bit      hold_done;
        hold_left = 0;
        hold_done = 0;
        out_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_if.valid && out_if.ready)
            begin
                got = out_if.payload;
                if (sps_expect_q.size() == 0)
                begin
                    report_mismatch("unexpected result count", 1, 0);
                end
                else
                begin
                    want = sps_expect_q.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.width_px != want.width_px)
                        report_mismatch("width_px", got.width_px, want.width_px);
                    if (got.height_px != want.height_px)
                        report_mismatch("height_px", got.height_px, want.height_px);
                    if (got.frame_rate != want.frame_rate)
                        report_mismatch("frame_rate", got.frame_rate, want.frame_rate);
                    if (got.rate_present != want.rate_present)
                        report_mismatch("rate_present", got.rate_present,
                                        want.rate_present);
                end
            end
            // hold off once for a long stretch
            if (hold_req && !hold_done)
            begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_if.ready <= 1'b0;
            end
            else
                out_if.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // offer one byte and wait for its transaction
    task automatic push_byte(logic [7:0] data, logic last, logic typed = 0,
                             result_t want = '0);
        while ($urandom_range(99) < idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= {last, data};
        do
            @(posedge clk);
        while (!in_if.ready);
        predict_byte(data, last, typed, want);
    endtask

    // bit writer for random parameter sets
    bit          sps_bits[$];
    logic [7:0]  unit_bytes[$];

    task automatic put_bits(longint unsigned v, int n);
        for (int i = n - 1; i >= 0; i--)
            sps_bits.push_back(v[i]);
    endtask

    task automatic put_ue(longint unsigned v);
        longint unsigned x;
        int nz;
        x  = v + 1;
        nz = 0;
        while ((x >> (nz + 1)) != 0)
            nz++;
        put_bits(0, nz);
        put_bits(x, nz + 1);
    endtask

    function automatic longint unsigned rand_code();
        int k;
        case ($urandom_range(9))
            0: return 64'hffff_fffe;
            1: begin k = $urandom_range(31, 1); return $urandom & ((64'd1 << k) - 1); end
            default: return $urandom_range(7);
        endcase
    endfunction

    // build one parameter set with random content, mostly well-formed
    task automatic build_sps();
        logic [7:0] prof;
        int         n;
        int         zr;
        logic [7:0] b;
        logic [7:0] raw[$];
        sps_bits.delete();
        unit_bytes.delete();
        put_bits({1'b0, 2'($urandom), NAL_SPS}, 8);
        case ($urandom_range(7))
            0: prof = 8'd66;
            1: prof = 8'd77;
            2: prof = 8'd100;
            3: prof = 8'd110;
            4: prof = 8'd122;
            5: prof = 8'd144;
            default: prof = 8'($urandom);
        endcase
        put_bits(prof, 8);
        put_bits($urandom, 8);
        put_bits($urandom, 8);
        put_ue(rand_code());
        if (prof inside {8'd100, 8'd110, 8'd122, 8'd144})
        begin
            n = $urandom_range(3);
            put_ue(n);
            if (n == 3)
                put_bits($urandom, 1);
            put_ue($urandom_range(6));
            put_ue($urandom_range(6));
            put_bits($urandom, 1);
            n = $urandom_range(1);
            put_bits(n, 1);
            if (n)
                put_bits($urandom, 8);
        end
        put_ue($urandom_range(12));
        n = $urandom_range(3);
        put_ue(n);
        if (n == 0)
            put_ue($urandom_range(12));
        else if (n == 1)
        begin
            put_bits($urandom, 1);
            put_ue(rand_code());
            put_ue(rand_code());
            n = $urandom_range(3);
            put_ue(n);
            repeat (n)
                put_ue(rand_code());
        end
        put_ue($urandom_range(16));
        put_bits($urandom, 1);
        // sizes, with the saturation boundary now and then
        put_ue(($urandom_range(5) == 0) ? 4094 + $urandom_range(2) : rand_code());
        put_ue(($urandom_range(5) == 0) ? 4094 + $urandom_range(2) : rand_code());
        n = $urandom_range(1);
        put_bits(n, 1);
        if (!n)
            put_bits($urandom, 1);
        put_bits($urandom, 1);
        n = $urandom_range(1);
        put_bits(n, 1);
        if (n)
            repeat (4)
                put_ue(rand_code());
        n = ($urandom_range(4) != 0);
        put_bits(n, 1);
        if (n)
        begin
            n = $urandom_range(1);
            put_bits(n, 1);
            if (n)
            begin
                b = ($urandom_range(2) == 0) ? AR_EXT_SAR : 8'($urandom);
                put_bits(b, 8);
                if (b == AR_EXT_SAR)
                    put_bits($urandom, 32);
            end
            n = $urandom_range(1);
            put_bits(n, 1);
            if (n)
                put_bits($urandom, 1);
            n = $urandom_range(1);
            put_bits(n, 1);
            if (n)
            begin
                b = 8'($urandom);
                put_bits(b, 5);
                if (b[0])
                    put_bits($urandom, 24);
            end
            n = $urandom_range(1);
            put_bits(n, 1);
            if (n)
            begin
                put_ue(rand_code());
                put_ue(rand_code());
            end
            n = ($urandom_range(3) != 0);
            put_bits(n, 1);
            if (n)
            begin
                case ($urandom_range(5))
                    0: put_bits(0, 32);
                    1: put_bits(1, 32);
                    2: put_bits(32'hffff_ffff, 32);
                    default: put_bits($urandom_range(5000, 1), 32);
                endcase
                put_bits(($urandom_range(3) == 0) ? $urandom : $urandom_range(120000),
                         32);
                put_bits($urandom, 1);
            end
        end
        // trailing stop bit, alignment and optional junk
        sps_bits.push_back(1'b1);
        while (sps_bits.size() % 8 != 0)
            sps_bits.push_back(1'b0);
        repeat ($urandom_range(3) == 0 ? $urandom_range(3) : 0)
            put_bits($urandom, 8);
        // occasionally break it with a long zero run
        if ($urandom_range(9) == 0)
            for (int i = 40; i < sps_bits.size(); i++)
                sps_bits[i] = 1'b0;
        for (int i = 0; i < sps_bits.size(); i += 8)
        begin
            for (int j = 0; j < 8; j++)
                b[7 - j] = sps_bits[i + j];
            raw.push_back(b);
        end
        // insert emulation-prevention bytes
        zr = 0;
        foreach (raw[i])
        begin
            if (zr >= 2 && raw[i] <= 8'd3)
            begin
                unit_bytes.push_back(EPB_BYTE);
                zr = 0;
            end
            unit_bytes.push_back(raw[i]);
            zr = (raw[i] == 0) ? zr + 1 : 0;
        end
        // cut some units short
        if ($urandom_range(6) == 0)
            while (unit_bytes.size() > 1 && $urandom_range(3) != 0)
                void'(unit_bytes.pop_back());
    endtask

    // stimulus
    initial
    begin : byte_side
        int sent;
        int len;
        err_count    = 0;
        idle_pct     = 32;
        hold_req     = 0;
        clear_walker();
        rst_n         = 1'b0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            push_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                      dir_rows[i].want);

        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            // no idling for one stretch, a long output stall in another
            idle_pct = (sent >= 380 && sent < 500) ? 0 : 32;
            if (sent >= 200)
                hold_req = 1;
            if ($urandom_range(5) == 0)
            begin
                // noise unit
                len = $urandom_range(10, 1);
                for (int i = 0; i < len; i++)
                    push_byte(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom),
                              i == len - 1);
                sent += len;
            end
            else
            begin
                build_sps();
                foreach (unit_bytes[i])
                    push_byte(unit_bytes[i], i == unit_bytes.size() - 1);
                sent += unit_bytes.size();
            end
        end
        in_if.valid <= 1'b0;

        // drain
        while (sps_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
